// ===== hdl/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// xtea_pkg: shared types and constants of the XTEA block cipher
// Holds the round constants, the key type and the data word that moves
// from cell to cell along the round chain.
// ----------------------------------------------------------------------------
package xtea_pkg;

  // Default number of full Feistel rounds.
  localparam int ROUND_COUNT_DEF = 32;

  // The golden ratio step, and its negation, which the encrypt path subtracts.
  localparam logic [31:0] DELTA     = 32'h9E3779B9;
  localparam logic [31:0] SUM_STEP  = 32'h61C88647;

  // Register map of the configuration port.
  localparam int KEY_WORDS  = 4;
  localparam int ADDR_WIDTH = 4;

  // Direction codes of the kind field.
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // Four key words, index 0 in the lowest slot.
  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  // One block in flight together with its running sum and side bits.
  typedef struct packed {
    logic        kind;
    logic        last;
    logic [31:0] sum;
    logic [31:0] v0;
    logic [31:0] v1;
  } lane_t;

  // Start value of the decrypt sum: rounds times delta, modulo 2^32.
  function automatic logic [31:0] dec_start_sum(input int rounds);
    logic [63:0] prod;
    prod = 64'(rounds) * {32'd0, DELTA};
    return prod[31:0];
  endfunction

endpackage

// ===== hdl/xtea_key_regs.sv =====
// ----------------------------------------------------------------------------
// xtea_key_regs: key register file behind the APB-style port
// Four 32-bit key words at byte addresses 0, 4, 8 and 12, written by a
// completed write transfer and read back on prdata.
// ----------------------------------------------------------------------------
module xtea_key_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xtea_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output xtea_pkg::key_t                key
);

  xtea_pkg::key_t key_r;
  xtea_pkg::key_t key_nxt;
  logic [1:0]     word_sel;
  logic           wr_en;

  assign pready   = 1'b1;
  assign word_sel = paddr[3:2];
  assign wr_en    = psel && penable && pwrite && pready;

  // Next value of the key words on a write transfer.
  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      key_nxt[word_sel] = pwdata;
    end
  end

  // Key storage, cleared to zero at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // Read back the addressed word.
  assign prdata = key_r[word_sel];
  assign key    = key_r;

endmodule

// ===== hdl/xtea_cell.sv =====
// ----------------------------------------------------------------------------
// xtea_cell: one half round of the XTEA chain
// Updates one of the two halves of the block it holds and hands the result
// to the next cell whenever the chain advances. Phase 0 cells also step
// the running sum.
// ----------------------------------------------------------------------------
module xtea_cell #(
  parameter logic PHASE = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  xtea_pkg::key_t  key,
  input  logic            valid_i,
  input  xtea_pkg::lane_t lane_i,
  output logic            valid_o,
  output xtea_pkg::lane_t lane_o
);

  logic            valid_r;
  logic            valid_nxt;
  xtea_pkg::lane_t lane_r;
  xtea_pkg::lane_t lane_nxt;

  logic        tgt_is_v0;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [1:0]  key_idx;
  logic [31:0] mix;
  logic [31:0] round_f;
  logic [31:0] tgt_new;

  // The half being updated is v0 when direction and phase agree.
  assign tgt_is_v0 = (lane_i.kind == PHASE);
  assign src       = tgt_is_v0 ? lane_i.v1 : lane_i.v0;
  assign tgt       = tgt_is_v0 ? lane_i.v0 : lane_i.v1;
  assign key_idx   = tgt_is_v0 ? lane_i.sum[1:0] : lane_i.sum[12:11];

  // Feistel function and the add or subtract into the target half.
  assign mix     = ((src << 4) ^ (src >> 5)) + src;
  assign round_f = mix ^ (lane_i.sum + key[key_idx]);
  assign tgt_new = (lane_i.kind == xtea_pkg::KIND_DECRYPT) ? (tgt - round_f)
                                                          : (tgt + round_f);

  // Assemble the word handed to the next cell.
  always_comb begin
    lane_nxt      = lane_i;
    valid_nxt     = valid_i;
    lane_nxt.v0   = tgt_is_v0 ? tgt_new : lane_i.v0;
    lane_nxt.v1   = tgt_is_v0 ? lane_i.v1 : tgt_new;
    if (PHASE == 1'b0) begin
      lane_nxt.sum = (lane_i.kind == xtea_pkg::KIND_DECRYPT)
                   ? (lane_i.sum + xtea_pkg::SUM_STEP)
                   : (lane_i.sum - xtea_pkg::SUM_STEP);
    end
  end

  // Valid flag with reset; the payload moves with the chain only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_r <= lane_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lane_o  = lane_r;

endmodule

// ===== hdl/xtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// xtea_block_cipher: pipelined XTEA encrypt and decrypt of 64-bit blocks
// A chain of 2*ROUND_COUNT half-round cells, one block per cycle while the chain is not stalled, with the
// 128-bit key in four APB-style configuration registers.
//
//   Channel  Direction  Ports                                      Transfer when
//   in       in         in_kind in_half_first in_half_second        in_valid & !in_stall
//                       in_last_block
//   out      out        out_result_first out_result_second          out_valid & !out_stall
//                       out_result_last
//   cfg      in/out     psel penable pwrite paddr pwdata prdata     psel & penable &
//                       pready                                     pwrite & pready
//
// One half round per cell; every cell registers its block.
// The chain accepts one block every cycle while the last cell is empty or taken.
// A stall while the output holds a block freezes the whole chain and raises in_stall.
// Reset clears all valid flags and sets the key words to zero.
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
  parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [31:0]                     in_half_first,
  input  logic [31:0]                     in_half_second,
  input  logic                            in_last_block,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     out_result_first,
  output logic [31:0]                     out_result_second,
  output logic                            out_result_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xtea_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int          CELLS     = 2 * ROUND_COUNT;
  localparam logic [31:0] DEC_START = xtea_pkg::dec_start_sum(ROUND_COUNT);

  xtea_pkg::key_t  key;
  logic            advance;
  logic            valid_w [0:CELLS];
  xtea_pkg::lane_t lane_w  [0:CELLS];

  // Key registers.
  xtea_key_regs u_key_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // The chain moves when the last cell is empty or its block is taken.
  assign advance  = !(valid_w[CELLS] && out_stall);
  assign in_stall = !advance;

  // Entry word: the sum starts at zero to encrypt and at the end value to decrypt.
  assign valid_w[0]     = in_valid;
  assign lane_w[0].kind = in_kind;
  assign lane_w[0].last = in_last_block;
  assign lane_w[0].sum  = (in_kind == xtea_pkg::KIND_DECRYPT) ? DEC_START : 32'd0;
  assign lane_w[0].v0   = in_half_first;
  assign lane_w[0].v1   = in_half_second;

  // Row of half-round cells, phases alternating.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xtea_cell #(
      .PHASE (1'(i % 2))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .key     (key),
      .valid_i (valid_w[i]),
      .lane_i  (lane_w[i]),
      .valid_o (valid_w[i+1]),
      .lane_o  (lane_w[i+1])
    );
  end

  // The last cell is the output register.
  assign out_valid         = valid_w[CELLS];
  assign out_result_first  = lane_w[CELLS].v0;
  assign out_result_second = lane_w[CELLS].v1;
  assign out_result_last   = lane_w[CELLS].last;

  // After all rounds the sum has run to the other end of its range.
  a_final_sum : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lane_w[CELLS].sum ==
                   ((lane_w[CELLS].kind == xtea_pkg::KIND_DECRYPT) ? 32'd0 : DEC_START)))
    else $error("final round sum does not match the direction");

  // An accepted block enters the first cell on the next edge.
  a_entry : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_w[1])
    else $error("accepted block did not enter the chain");

  // Without a write transfer the key does not change.
  a_key_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !(psel && penable && pwrite) |=> $stable(key))
    else $error("key changed without a write transfer");

  // A stalled chain keeps its output block.
  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(lane_w[CELLS])))
    else $error("output block changed during a stall");

endmodule

// ===== tb/sv/tb_xtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_xtea_block_cipher: self-checking bench for the pipelined XTEA cipher
// Loads several 128-bit keys over the register port and reads them back.
// Sends encrypt and decrypt blocks through a bursty sender against a
// receiver that stalls in changing modes. Every result is compared field by
// field with a block computed here from the same key.
// ----------------------------------------------------------------------------
module tb_xtea_block_cipher;

  localparam int ROUNDS = xtea_pkg::ROUND_COUNT_DEF;
  localparam logic [31:0] GOLDEN_STEP = 32'h9E3779B9;
  localparam int REG_STRIDE = 4;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 400000;

  // One cipher result as it leaves the block.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic        eob;
  } xtea_out_t;

  // Receiver behavior, switched between these modes at random.
  typedef enum logic [1:0] {RX_STEADY, RX_SPARSE, RX_HEAVY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = xtea_pkg::KIND_ENCRYPT;
  logic [31:0] in_half_first = '0;
  logic [31:0] in_half_second = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_first;
  logic [31:0] out_result_second;
  logic        out_result_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [xtea_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] key_shadow [xtea_pkg::KEY_WORDS];
  xtea_out_t   blocks_in_flight [$];
  xtea_out_t   head_blk;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  rx_mode_t    rx_mode = RX_STEADY;
  int          rx_seg_left = 0;

  xtea_block_cipher i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_half_first     (in_half_first),
    .in_half_second    (in_half_second),
    .in_last_block     (in_last_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_first  (out_result_first),
    .out_result_second (out_result_second),
    .out_result_last   (out_result_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The run is cut off if it never reaches its normal end.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("xtea_block_cipher regression: fail");
    $finish;
  end

  // Prints one line per mismatch and keeps count.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // The shift-and-add mixing term of one half round.
  function automatic logic [31:0] xtea_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Full XTEA on one block with the key currently loaded.
  function automatic xtea_out_t xtea_rounds(input logic dir, input logic [31:0] a,
                                            input logic [31:0] b, input logic eob);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    xtea_out_t res;
    int r;
    y = a;
    z = b;
    s = '0;
    if (dir == xtea_pkg::KIND_DECRYPT) begin
      for (r = 0; r < ROUNDS; r++) s += GOLDEN_STEP;
      for (r = 0; r < ROUNDS; r++) begin
        z -= xtea_mix(y) ^ (s + key_shadow[s[12:11]]);
        s -= GOLDEN_STEP;
        y -= xtea_mix(z) ^ (s + key_shadow[s[1:0]]);
      end
    end else begin
      for (r = 0; r < ROUNDS; r++) begin
        y += xtea_mix(z) ^ (s + key_shadow[s[1:0]]);
        s += GOLDEN_STEP;
        z += xtea_mix(y) ^ (s + key_shadow[s[12:11]]);
      end
    end
    res.w0 = y;
    res.w1 = z;
    res.eob = eob;
    return res;
  endfunction

  // Random word, biased toward the corner values.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: steady, sparse or heavy stalling, switched at random.
  always @(posedge clk) begin
    if (rx_seg_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_seg_left <= $urandom_range(20, 200);
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    case (rx_mode)
      RX_STEADY: out_stall <= 1'b0;
      RX_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
      default:   out_stall <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // Each result transfer is compared with the oldest block in flight.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (blocks_in_flight.size() == 0) begin
        report_mismatch("result with no block in flight");
      end else begin
        head_blk = blocks_in_flight.pop_front();
        if (out_result_first !== head_blk.w0)
          report_mismatch($sformatf("result_first %h, want %h", out_result_first,
                                    head_blk.w0));
        if (out_result_second !== head_blk.w1)
          report_mismatch($sformatf("result_second %h, want %h", out_result_second,
                                    head_blk.w1));
        if (out_result_last !== head_blk.eob)
          report_mismatch($sformatf("result_last %b, want %b", out_result_last,
                                    head_blk.eob));
      end
    end
  end

  // Sends one block, with bursts and random gaps in between.
  task automatic send_block(input logic dir, input logic [31:0] a, input logic [31:0] b,
                            input logic eob);
    xtea_out_t predicted;
    int gap;
    predicted = xtea_rounds(dir, a, b, eob);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= dir;
    in_half_first <= a;
    in_half_second <= b;
    in_last_block <= eob;
    do @(posedge clk); while (in_stall);
    blocks_in_flight.push_back(predicted);
  endtask

  // Lowers valid and waits until every block has come back.
  task automatic drain_blocks();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (blocks_in_flight.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= xtea_pkg::ADDR_WIDTH'(idx * REG_STRIDE);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_shadow[idx] = value;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register read, compared with the value last written.
  task automatic cfg_readback(input int idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= xtea_pkg::ADDR_WIDTH'(idx * REG_STRIDE);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== key_shadow[idx])
      report_mismatch($sformatf("key word %0d reads %h, want %h", idx, prdata,
                                key_shadow[idx]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads a whole key and reads every word back.
  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    logic [31:0] words [xtea_pkg::KEY_WORDS];
    words = '{k0, k1, k2, k3};
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) cfg_write(i, words[i]);
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) cfg_readback(i);
  endtask

  // Corner blocks in both directions under the key currently loaded.
  task automatic send_corner_blocks();
    send_block(xtea_pkg::KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_block(xtea_pkg::KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_block(xtea_pkg::KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_block(xtea_pkg::KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_block(xtea_pkg::KIND_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_block(xtea_pkg::KIND_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
  endtask

  // The key after reset is all zero; checks readback and corner blocks.
  task automatic test_reset_key();
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) cfg_readback(i);
    send_corner_blocks();
    drain_blocks();
  endtask

  // All-ones key, then a key whose words differ, so word selection shows.
  task automatic test_key_extremes();
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_corner_blocks();
    drain_blocks();
    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_corner_blocks();
    drain_blocks();
  endtask

  // Encrypts random plaintext and decrypts the ciphertext right after it.
  task automatic test_round_trip();
    xtea_out_t ct;
    logic [31:0] p0;
    logic [31:0] p1;
    logic eob;
    for (int k = 0; k < 4; k++) begin
      load_key(rand_word(), rand_word(), $urandom, $urandom);
      for (int n = 0; n < 40; n++) begin
        p0 = rand_word();
        p1 = rand_word();
        eob = ($urandom_range(0, 3) == 0);
        ct = xtea_rounds(xtea_pkg::KIND_ENCRYPT, p0, p1, eob);
        send_block(xtea_pkg::KIND_ENCRYPT, p0, p1, eob);
        send_block(xtea_pkg::KIND_DECRYPT, ct.w0, ct.w1, ct.eob);
      end
      drain_blocks();
    end
  endtask

  // Random blocks and directions under several keys; the last key runs
  // with the sender never idling.
  task automatic test_random_blocks();
    logic [31:0] keys [4][xtea_pkg::KEY_WORDS];
    keys[0] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    keys[1] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    keys[2] = '{$urandom, $urandom, $urandom, $urandom};
    keys[3] = '{$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < 4; k++) begin
      load_key(keys[k][0], keys[k][1], keys[k][2], keys[k][3]);
      no_gaps = (k == 3);
      for (int n = 0; n < 55; n++)
        send_block($urandom_range(0, 1) ? xtea_pkg::KIND_DECRYPT : xtea_pkg::KIND_ENCRYPT,
                   rand_word(), rand_word(), ($urandom_range(0, 3) == 0));
      drain_blocks();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) key_shadow[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_key();
    test_key_extremes();
    test_round_trip();
    test_random_blocks();
    drain_blocks();
    repeat (2 * ROUNDS + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("xtea_block_cipher regression: pass");
    end else begin
      $display("xtea_block_cipher regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/xtea_pkg.sv
hdl/xtea_key_regs.sv
hdl/xtea_cell.sv
hdl/xtea_block_cipher.sv
tb/sv/tb_xtea_block_cipher.sv
